// File: hdl/sale_pkg.sv
// Shared types, sizes and codes for the sorted array list engine.
`timescale 1ns / 1ps
`default_nettype none

package sale_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_REAR   = 3'd1,
    CMD_INS_POS    = 3'd2,
    CMD_INS_SORTED = 3'd3,
    CMD_DEL_FRONT  = 3'd4,
    CMD_DEL_REAR   = 3'd5,
    CMD_DEL_POS    = 3'd6,
    CMD_READ       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  age;
    logic [15:0] id;
    logic [3:0]  month;
    logic [11:0] year;
  } rec_t;

  // Broadcast to every cell for one command.
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic             sorted;
    logic [CMP_W-1:0] at;
    logic [CMP_W-1:0] count;
    rec_t             new_rec;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/sale_if.sv
// Command and result channel interfaces of the sorted array list engine.
`timescale 1ns / 1ps
`default_nettype none

interface sale_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [5:0]  position;
  logic [7:0]  entry_age;
  logic [15:0] entry_id;
  logic [3:0]  entry_month;
  logic [11:0] entry_year;

  modport source (output valid, command, position, entry_age, entry_id, entry_month,
                  entry_year, input ready);
  modport sink   (input valid, command, position, entry_age, entry_id, entry_month,
                  entry_year, output ready);
endinterface

interface sale_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  entry_count;
  logic [7:0]  read_age;
  logic [15:0] read_id;
  logic [3:0]  read_month;
  logic [11:0] read_year;

  modport source (output valid, status, entry_count, read_age, read_id, read_month,
                  read_year, input ready);
  modport sink   (input valid, status, entry_count, read_age, read_id, read_month,
                  read_year, output ready);
endinterface

`default_nettype wire

// File: hdl/sale_cell.sv
// One list slot: holds a record, finds the target slot and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sale_cell
  import sale_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire cell_ctl_t        ctl,
  input  wire logic             found_in,
  output logic                  found_out,
  input  wire rec_t             rd_in,
  output rec_t                  rd_out,
  input  wire rec_t             left_rec,
  input  wire rec_t             right_rec,
  output rec_t                  rec_q
);

  rec_t             rec_r;
  rec_t             rec_nxt;
  logic [CMP_W-1:0] idx_ext;
  logic             hit;

  assign idx_ext = CMP_W'(cell_idx);

  // Sorted insert stops at the first slot at or past the count or with a greater age.
  always_comb begin
    if (ctl.sorted) begin
      hit = (idx_ext >= ctl.count) || (rec_r.age > ctl.new_rec.age);
    end else begin
      hit = (idx_ext == ctl.at);
    end
  end

  assign found_out = found_in | hit;
  assign rd_out    = hit ? rec_r : rd_in;
  assign rec_q     = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins_en) begin
      if (found_in) begin
        rec_nxt = left_rec;
      end else if (hit) begin
        rec_nxt = ctl.new_rec;
      end
    end else if (ctl.del_en) begin
      if (found_in || hit) begin
        rec_nxt = right_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/sorted_array_list_engine_core.sv
// Top level of the sorted array list engine: command decode, cell row, result register.
//
//   channel  | direction | beat contents
//   ---------+-----------+-------------------------------------------------------
//   in_chan  | sink      | command, position, entry_age/id/month/year
//   out_chan | source    | status, entry_count, read_age/id/month/year
//
// The whole row of cells settles in the cycle the beat is accepted, so the rate is one
// beat per cycle while the result register drains; the clock is limited by the ripple of the
// target search and read select through the row of CAPACITY cells.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// A stalled result holds in the output register; a new beat is taken in the same
// cycle the pending result leaves.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_list_engine_core
  import sale_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sale_in_if.sink   in_chan,
  sale_out_if.source out_chan
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic    out_valid_r;
  status_t status_r;
  status_t status_nxt;
  logic [CNT_W-1:0] out_count_r;
  rec_t    rd_r;
  rec_t    rd_nxt;

  logic accept;
  cmd_t cmd;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] at;
  logic is_ins;
  logic full;
  logic empty;
  logic bad;
  logic sorted;
  cell_ctl_t ctl;

  // Row chains: the found flag and read select ripple from slot 0 upward.
  logic found_chain [CAPACITY+1];
  rec_t rd_chain    [CAPACITY+1];
  rec_t rec_q       [CAPACITY];

  // Take a new beat whenever the result register is free or draining.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign cmd       = cmd_t'(in_chan.command);
  assign pos_ext   = CMP_W'(in_chan.position);
  assign count_ext = CMP_W'(count_r);
  assign is_ins    = !in_chan.command[2];
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign sorted    = (cmd == CMD_INS_SORTED);

  // Pick the target slot; sorted insert finds its own in the row.
  always_comb begin
    unique case (cmd)
      CMD_INS_FRONT, CMD_DEL_FRONT: at = '0;
      CMD_INS_REAR:                 at = count_ext;
      CMD_DEL_REAR:                 at = count_ext - CMP_W'(1);
      CMD_INS_SORTED:               at = '0;
      default:                      at = pos_ext;
    endcase
  end

  // Inserts may land at the count (append); deletes and reads must stay below it.
  assign bad = is_ins ? (!sorted && (at > count_ext)) : (at >= count_ext);

  always_comb begin
    ctl.ins_en  = accept && is_ins && !full && !bad;
    ctl.del_en  = accept && !is_ins && (cmd != CMD_READ) && !empty && !bad;
    ctl.sorted  = sorted;
    ctl.at      = at;
    ctl.count   = count_ext;
    ctl.new_rec = '{age: in_chan.entry_age, id: in_chan.entry_id,
                    month: in_chan.entry_month, year: in_chan.entry_year};
  end

  assign found_chain[0] = 1'b0;
  assign rd_chain[0]    = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left_rec;
    rec_t right_rec;

    if (i == 0) begin : g_first
      assign left_rec = rec_q[i];
    end else begin : g_mid_l
      assign left_rec = rec_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = rec_q[i];
    end else begin : g_mid_r
      assign right_rec = rec_q[i+1];
    end

    sale_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(i)),
      .ctl       (ctl),
      .found_in  (found_chain[i]),
      .found_out (found_chain[i+1]),
      .rd_in     (rd_chain[i]),
      .rd_out    (rd_chain[i+1]),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .rec_q     (rec_q[i])
    );
  end

  always_comb begin
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Full and empty checks come before the position check.
  always_comb begin
    rd_nxt = '0;
    if (is_ins) begin
      priority if (full) begin
        status_nxt = ST_FULL;
      end else if (bad) begin
        status_nxt = ST_BAD_POS;
      end else begin
        status_nxt = ST_OK;
      end
    end else begin
      priority if (empty) begin
        status_nxt = ST_EMPTY;
      end else if (bad) begin
        status_nxt = ST_BAD_POS;
      end else begin
        status_nxt = ST_OK;
        if (cmd == CMD_READ) begin
          rd_nxt = rd_chain[CAPACITY];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on an accepted beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      out_count_r <= count_nxt;
      rd_r        <= rd_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.entry_count = 6'(out_count_r);
  assign out_chan.read_age    = rd_r.age;
  assign out_chan.read_id     = rd_r.id;
  assign out_chan.read_month  = rd_r.month;
  assign out_chan.read_year   = rd_r.year;

endmodule

`default_nettype wire

// File: tb/sv/tb_sorted_array_list_engine_core.sv
// Self-checking testbench for the sorted array list engine: directed and random command beats.
`timescale 1ns / 1ps

module tb_sorted_array_list_engine_core;
  import sale_pkg::*;

  localparam int unsigned RANDOM_BEATS = 800;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    cmd_t       command;
    logic [5:0] position;
    rec_t       rec;
  } list_cmd_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] count;
    rec_t       rd;
  } list_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sale_in_if  cmd_if ();
  sale_out_if res_if ();

  sorted_array_list_engine_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (cmd_if),
    .out_chan(res_if)
  );

  // Driven copies of the channel inputs, known from time zero.
  logic      drv_valid = 1'b0;
  list_cmd_t drv_beat  = '0;
  logic      res_take  = 1'b0;

  assign cmd_if.valid       = drv_valid;
  assign cmd_if.command     = drv_beat.command;
  assign cmd_if.position    = drv_beat.position;
  assign cmd_if.entry_age   = drv_beat.rec.age;
  assign cmd_if.entry_id    = drv_beat.rec.id;
  assign cmd_if.entry_month = drv_beat.rec.month;
  assign cmd_if.entry_year  = drv_beat.rec.year;
  assign res_if.ready       = res_take;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];

  // Shadow list kept by the predictor.
  rec_t        list_slot [CAPACITY];
  int unsigned list_len = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned beats_in       = 0;
  int unsigned beats_out      = 0;
  int unsigned cmd_seen [8];
  int unsigned status_seen [4];
  int unsigned peak_len = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one command to the shadow list and return the result it must produce.
  function automatic list_result_t apply_list_command(input list_cmd_t c);
    list_result_t r;
    int unsigned  at;
    int unsigned  i;
    r        = '0;
    r.status = ST_OK;
    at       = 0;
    case (c.command)
      CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_POS, CMD_INS_SORTED: begin
        // Full is checked before the position.
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          case (c.command)
            CMD_INS_FRONT: at = 0;
            CMD_INS_REAR:  at = list_len;
            CMD_INS_POS:   at = c.position;
            default: begin
              // Land after every entry whose age is not greater: ties stay in arrival order.
              while (at < list_len && list_slot[at].age <= c.rec.age) at++;
            end
          endcase
          if (at > list_len) begin
            r.status = ST_BAD_POS;
          end else begin
            for (i = list_len; i > at; i--) list_slot[i] = list_slot[i - 1];
            list_slot[at] = c.rec;
            list_len++;
          end
        end
      end
      default: begin
        // Empty is checked before the position.
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          case (c.command)
            CMD_DEL_FRONT: at = 0;
            CMD_DEL_REAR:  at = list_len - 1;
            default:       at = c.position;
          endcase
          if (at >= list_len) begin
            r.status = ST_BAD_POS;
          end else if (c.command == CMD_READ) begin
            r.rd = list_slot[at];
          end else begin
            for (i = at; i + 1 < list_len; i++) list_slot[i] = list_slot[i + 1];
            list_len--;
          end
        end
      end
    endcase
    r.count = list_len[5:0];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long; none at all in a quiet stretch.
  function automatic int unsigned draw_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got, input int unsigned beat);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: result %0d %s expected 0x%0h actual 0x%0h", $time, beat, label,
               want, got);
    end
  endtask

  // Driver: present the next pending command once the current beat is taken.
  int unsigned cmd_hold  = 0;
  bit          cmd_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      drv_beat  <= '0;
      cmd_hold  <= 0;
    end else if (!drv_valid || cmd_if.ready) begin
      if (cmd_hold != 0) begin
        drv_valid <= 1'b0;
        cmd_hold  <= cmd_hold - 1;
      end else if (pending_cmds.size() != 0) begin
        drv_beat  <= pending_cmds.pop_front();
        drv_valid <= 1'b1;
        cmd_hold  <= draw_gap(cmd_quiet);
        if ($urandom_range(0, 49) == 0) cmd_quiet <= !cmd_quiet;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  int unsigned res_stall = 0;
  bit          res_quiet = 1'b0;
  int unsigned res_draw;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_take  <= 1'b0;
      res_stall <= 0;
    end else if (res_stall != 0) begin
      res_take  <= 1'b0;
      res_stall <= res_stall - 1;
    end else begin
      res_draw = draw_gap(res_quiet);
      res_take <= (res_draw == 0);
      if (res_draw != 0) res_stall <= res_draw - 1;
      if ($urandom_range(0, 199) == 0) res_quiet <= !res_quiet;
    end
  end

  // Monitor: predict on every accepted command, then check every accepted result.
  list_cmd_t    seen_cmd;
  list_result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) begin
        seen_cmd.command   = cmd_t'(cmd_if.command);
        seen_cmd.position  = cmd_if.position;
        seen_cmd.rec.age   = cmd_if.entry_age;
        seen_cmd.rec.id    = cmd_if.entry_id;
        seen_cmd.rec.month = cmd_if.entry_month;
        seen_cmd.rec.year  = cmd_if.entry_year;
        want = apply_list_command(seen_cmd);
        expected_results.push_back(want);
        cmd_seen[cmd_if.command]++;
        status_seen[want.status]++;
        if (list_len > peak_len) peak_len = list_len;
        beats_in++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result, expected none, actual status %0d count %0d",
                   $time, res_if.status, res_if.entry_count);
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, res_if.status, beats_out);
          check_field("entry_count", want.count, res_if.entry_count, beats_out);
          check_field("read_age", want.rd.age, res_if.read_age, beats_out);
          check_field("read_id", want.rd.id, res_if.read_id, beats_out);
          check_field("read_month", want.rd.month, res_if.read_month, beats_out);
          check_field("read_year", want.rd.year, res_if.read_year, beats_out);
        end
        beats_out++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still expected", $time, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus planning: track the count the block will hold, to steer positions.
  int unsigned plan_len = 0;

  function automatic int unsigned len_after(input cmd_t c, input int unsigned pos,
                                            input int unsigned len);
    case (c)
      CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_SORTED: return (len < CAPACITY) ? len + 1 : len;
      CMD_INS_POS:  return (len < CAPACITY && pos <= len) ? len + 1 : len;
      CMD_DEL_FRONT, CMD_DEL_REAR: return (len != 0) ? len - 1 : len;
      CMD_DEL_POS:  return (len != 0 && pos < len) ? len - 1 : len;
      default:      return len;
    endcase
  endfunction

  task automatic queue_cmd(input cmd_t c, input int unsigned pos, input logic [7:0] age,
                           input logic [15:0] id, input logic [3:0] month,
                           input logic [11:0] year);
    list_cmd_t b;
    b.command   = c;
    b.position  = pos[5:0];
    b.rec.age   = age;
    b.rec.id    = id;
    b.rec.month = month;
    b.rec.year  = year;
    pending_cmds.push_back(b);
    plan_len = len_after(c, pos[5:0], plan_len);
  endtask

  // Position steering: mostly in range, sometimes at the edges, sometimes anywhere.
  function automatic int unsigned pick_position(input int unsigned len);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(0, len);
    if (roll < 90) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return (len != 0) ? len - 1 : 0;
        2:       return len;
        default: return len + 1;
      endcase
    end
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [7:0] pick_age();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    // Narrow ages give plenty of ties for the sorted insert.
    if (roll < 60) return 8'($urandom_range(0, 7));
    if (roll < 70) return (roll < 65) ? 8'd0 : 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned n;
    int unsigned phase;
    int unsigned roll;
    cmd_t        c;

    // Directed: empty list, bad positions, extremes of every field, ties, every command.
    queue_cmd(CMD_READ, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_FRONT, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_REAR, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_POS, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_INS_POS, 1, 8'd9, 16'd9, 4'd9, 12'd9);
    queue_cmd(CMD_INS_POS, 63, 8'hFF, 16'hFFFF, 4'hF, 12'hFFF);
    queue_cmd(CMD_INS_POS, 0, 8'hFF, 16'hFFFF, 4'hF, 12'hFFF);
    queue_cmd(CMD_INS_FRONT, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_INS_REAR, 0, 8'd128, 16'h5A5A, 4'h5, 12'hA5A);
    queue_cmd(CMD_INS_SORTED, 0, 8'd128, 16'hA5A5, 4'hA, 12'h5A5);
    queue_cmd(CMD_INS_SORTED, 0, 8'd0, 16'h1234, 4'h1, 12'h234);
    queue_cmd(CMD_INS_SORTED, 0, 8'hFF, 16'h8001, 4'h8, 12'h801);
    queue_cmd(CMD_INS_SORTED, 0, 8'd1, 16'h0F0F, 4'h3, 12'h0F0);
    queue_cmd(CMD_INS_POS, plan_len, 8'd77, 16'h7777, 4'h7, 12'h777);
    queue_cmd(CMD_READ, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_READ, plan_len - 1, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_READ, plan_len, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_READ, 63, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_POS, plan_len, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_POS, 63, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_POS, 1, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_REAR, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_DEL_FRONT, 0, 8'd0, 16'd0, 4'd0, 12'd0);
    queue_cmd(CMD_READ, 0, 8'd0, 16'd0, 4'd0, 12'd0);

    // Random: sweep the list between empty and full, with mixed stretches and noise.
    phase = 0;  // 0 fill, 1 drain, 2 mixed
    for (n = 0; n < RANDOM_BEATS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        c = cmd_t'($urandom_range(0, 7));
        queue_cmd(c, $urandom_range(0, 63), 8'($urandom), 16'($urandom), 4'($urandom),
                  12'($urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < ((phase == 0) ? 85 : (phase == 1) ? 15 : 50)) begin
          case ($urandom_range(0, 5))
            0:       c = CMD_INS_FRONT;
            1:       c = CMD_INS_REAR;
            2:       c = CMD_INS_POS;
            default: c = CMD_INS_SORTED;
          endcase
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    c = CMD_DEL_FRONT;
            2, 3:    c = CMD_DEL_REAR;
            4, 5, 6: c = CMD_DEL_POS;
            default: c = CMD_READ;
          endcase
        end
        queue_cmd(c, pick_position(plan_len), pick_age(), 16'($urandom), 4'($urandom),
                  12'($urandom));
      end
      // Linger at full and empty for a few beats before turning around.
      if (phase == 0 && plan_len == CAPACITY && $urandom_range(0, 3) == 0) phase = 1;
      else if (phase == 1 && plan_len == 0 && $urandom_range(0, 3) == 0)
        phase = $urandom_range(0, 1) ? 0 : 2;
      else if (phase == 2 && $urandom_range(0, 39) == 0) phase = $urandom_range(0, 1);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || drv_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: %0d results never arrived", $time, expected_results.size());
    end

    $display("Ran %0d commands (ins %0d/%0d/%0d/%0d, del %0d/%0d/%0d, read %0d), peak count %0d",
             beats_in, cmd_seen[CMD_INS_FRONT], cmd_seen[CMD_INS_REAR], cmd_seen[CMD_INS_POS],
             cmd_seen[CMD_INS_SORTED], cmd_seen[CMD_DEL_FRONT], cmd_seen[CMD_DEL_REAR],
             cmd_seen[CMD_DEL_POS], cmd_seen[CMD_READ], peak_len);
    $display("Statuses ok %0d, full %0d, empty %0d, bad position %0d; %0d results checked",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BAD_POS], beats_out);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
